@@ rtl/core/fsand_pkg.sv @@
// Package for the falling sand grid engine: material codes, request codes,
// default sizes, random step and datapath commands. No dependencies.
package fsand_pkg;
   localparam int GRID_COLS_DEF  = 64;
   localparam int GRID_ROWS_DEF  = 64;
   localparam int SIDE_REACH_DEF = 3;

   localparam logic [2:0] K_EMPTY = 3'd0;
   localparam logic [2:0] K_SAND  = 3'd1;
   localparam logic [2:0] K_WATER = 3'd2;
   localparam logic [2:0] K_STONE = 3'd3;
   localparam logic [2:0] K_SNOW  = 3'd4;

   localparam logic [1:0] F_WRITE = 2'd0;
   localparam logic [1:0] F_READ  = 2'd1;
   localparam logic [1:0] F_TICK  = 2'd2;

   localparam logic [15:0] LFSR_TAPS = 16'hB400;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic rd;      // issue a memory read at the selected address
      logic wr;      // write the selected data at the selected address
      logic draw;    // advance the random generator
   } dp_cmd_type;

   function automatic logic [15:0] lfsr_next(input logic [15:0] v);
      logic [15:0] s;
      s = {1'b0, v[15:1]};
      if (v[0]) s = s ^ LFSR_TAPS;
      return s;
   endfunction
endpackage

@@ rtl/core/fsand_mem.sv @@
// Grid store of the falling sand engine: one write port, one registered read.
// Depends on nothing beyond its parameters.
module fsand_mem #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [2:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [2:0]    rd_data
);
   logic [2:0] mem [DEPTH];
   logic [2:0] rd_ff;

   // The read data holds until the next enabled read.
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_ff <= mem[rd_addr];
   end
   assign rd_data = rd_ff;
endmodule

@@ rtl/core/fsand_ctrl.sv @@
// Controller of the falling sand engine: clearing pass, request handling and
// the cell-by-cell tick sequencer. Depends on fsand_pkg.
module fsand_ctrl #(
   parameter int GRID_COLS  = fsand_pkg::GRID_COLS_DEF,
   parameter int GRID_ROWS  = fsand_pkg::GRID_ROWS_DEF,
   parameter int SIDE_REACH = fsand_pkg::SIDE_REACH_DEF,
   parameter int CW = 6,
   parameter int RW = 6
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_func,
   input  logic [5:0]        req_col,
   input  logic [5:0]        req_row,
   input  logic [2:0]        req_cell_kind,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_op_echo,
   output logic [2:0]        rsp_read_kind,
   input  logic              rnd_bit,
   input  logic [2:0]        mem_rdata,
   output fsand_pkg::dp_cmd_type cmd,
   output logic [CW-1:0]     acol,
   output logic [RW-1:0]     arow,
   output logic [2:0]        wdata
);
   localparam int SW = $clog2(SIDE_REACH + 1);
   localparam logic [CW:0] LAST_COL = (CW+1)'(GRID_COLS - 1);
   localparam logic [3:0]
      S_CLEAR = 4'd0, S_IDLE = 4'd1, S_READ = 4'd2, S_ROW = 4'd3,
      S_HERE = 4'd4, S_KIND = 4'd5, S_BELOW = 4'd6, S_DIAG = 4'd7,
      S_DGOT = 4'd8, S_SIDE = 4'd9, S_SGOT = 4'd10, S_SWAP = 4'd11,
      S_SWB = 4'd12, S_NEXT = 4'd13;

   logic [3:0] state_ff, state_in;
   logic [CW-1:0] x_ff, x_in, tx_ff, tx_in;
   logic [RW-1:0] y_ff, y_in, ty_ff, ty_in;
   logic [CW:0]   cnt_ff, cnt_in;
   logic ltr_ff, ltr_in, dleft_ff, dleft_in, try2_ff, try2_in;
   logic [SW-1:0] step_ff, step_in;
   logic [2:0] kind_ff, kind_in, okind_ff, okind_in, rk_ff, rk_in;
   logic [1:0] op_ff, op_in;
   logic rv_ff, rv_in;
   logic [CW+RW-1:0] clr_ff, clr_in;

   logic          in_grid;
   logic [RW-1:0] y_down;
   logic          sink_ok;   // the cell on mem_rdata can take the visited material
   logic          moving;
   int            offs;
   int            ncand;
   logic          nok;

   assign in_grid = (int'(req_col) < GRID_COLS) && (int'(req_row) < GRID_ROWS);
   assign y_down = y_ff + RW'(1);
   assign sink_ok = (mem_rdata == fsand_pkg::K_EMPTY) ||
                    (mem_rdata == fsand_pkg::K_WATER && kind_ff != fsand_pkg::K_WATER);
   assign moving = (mem_rdata == fsand_pkg::K_SAND) || (mem_rdata == fsand_pkg::K_SNOW) ||
                   (mem_rdata == fsand_pkg::K_WATER);
   assign req_ready = (state_ff == S_IDLE) && !rv_ff;
   assign rsp_valid = rv_ff;
   assign rsp_op_echo = op_ff;
   assign rsp_read_kind = rk_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         rv_ff <= rv_in;
      end
      x_ff <= x_in; y_ff <= y_in; tx_ff <= tx_in; ty_ff <= ty_in;
      cnt_ff <= cnt_in; ltr_ff <= ltr_in; dleft_ff <= dleft_in; try2_ff <= try2_in;
      step_ff <= step_in; kind_ff <= kind_in; okind_ff <= okind_in;
      rk_ff <= rk_in; op_ff <= op_in;
   end

   always_comb begin
      state_in = state_ff; clr_in = clr_ff; rv_in = rv_ff;
      x_in = x_ff; y_in = y_ff; tx_in = tx_ff; ty_in = ty_ff;
      cnt_in = cnt_ff; ltr_in = ltr_ff; dleft_in = dleft_ff; try2_in = try2_ff;
      step_in = step_ff; kind_in = kind_ff; okind_in = okind_ff;
      rk_in = rk_ff; op_in = op_ff;
      cmd = '0; acol = x_ff; arow = y_ff; wdata = fsand_pkg::K_EMPTY;
      // Candidate column: one step for a diagonal, step_ff cells for water sideways.
      offs = (state_ff == S_SIDE) ? int'(step_ff) : 1;
      ncand = dleft_ff ? int'(x_ff) - offs : int'(x_ff) + offs;
      nok = (ncand >= 0) && (ncand < GRID_COLS);
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            acol = clr_ff[CW-1:0];
            arow = clr_ff[CW+RW-1:CW];
            cmd.wr = 1'b1;
            clr_in = clr_ff + (CW+RW)'(1);
            if (clr_ff == {(CW+RW){1'b1}}) state_in = S_IDLE;
         end
         S_IDLE: begin
            acol = CW'(req_col);
            arow = RW'(req_row);
            wdata = req_cell_kind;
            if (req_valid && req_ready) begin
               op_in = req_func;
               rk_in = fsand_pkg::K_EMPTY;
               unique case (req_func)
                  fsand_pkg::F_WRITE: begin
                     cmd.wr = in_grid && (req_cell_kind <= fsand_pkg::K_SNOW);
                     rv_in = 1'b1;
                  end
                  fsand_pkg::F_READ: begin
                     cmd.rd = in_grid;
                     state_in = in_grid ? S_READ : S_IDLE;
                     rv_in = !in_grid;
                  end
                  fsand_pkg::F_TICK: begin
                     y_in = RW'(GRID_ROWS - 2);
                     state_in = S_ROW;
                  end
                  default: begin
                     rv_in = 1'b1;
                  end
               endcase
            end
         end
         S_READ: begin
            rk_in = mem_rdata;
            rv_in = 1'b1;
            state_in = S_IDLE;
         end
         S_ROW: begin
            cmd.draw = 1'b1;
            ltr_in = !rnd_bit;
            x_in = rnd_bit ? CW'(GRID_COLS - 1) : '0;
            cnt_in = '0;
            state_in = S_HERE;
         end
         S_HERE: begin
            cmd.rd = 1'b1;
            state_in = S_KIND;
         end
         S_KIND: begin
            // The visited cell is on mem_rdata; fetch the one below if it can move.
            kind_in = mem_rdata;
            if (moving) begin
               arow = y_down;
               cmd.rd = 1'b1;
               state_in = S_BELOW;
            end else begin
               state_in = S_NEXT;
            end
         end
         S_BELOW: begin
            if (sink_ok) begin
               tx_in = x_ff; ty_in = y_down; okind_in = mem_rdata;
               state_in = S_SWAP;
            end else begin
               cmd.draw = 1'b1;
               dleft_in = !rnd_bit;
               try2_in = 1'b0;
               state_in = S_DIAG;
            end
         end
         S_DIAG: begin
            if (nok) begin
               acol = CW'(ncand); arow = y_down; cmd.rd = 1'b1;
               tx_in = CW'(ncand); ty_in = y_down;
               state_in = S_DGOT;
            end else if (!try2_ff) begin
               try2_in = 1'b1; dleft_in = !dleft_ff;
            end else if (kind_ff == fsand_pkg::K_WATER) begin
               cmd.draw = 1'b1; dleft_in = rnd_bit; step_in = SW'(1);
               state_in = S_SIDE;
            end else begin
               state_in = S_NEXT;
            end
         end
         S_DGOT: begin
            if (sink_ok) begin
               okind_in = mem_rdata;
               state_in = S_SWAP;
            end else if (!try2_ff) begin
               try2_in = 1'b1; dleft_in = !dleft_ff;
               state_in = S_DIAG;
            end else if (kind_ff == fsand_pkg::K_WATER) begin
               cmd.draw = 1'b1; dleft_in = rnd_bit; step_in = SW'(1);
               state_in = S_SIDE;
            end else begin
               state_in = S_NEXT;
            end
         end
         S_SIDE: begin
            // The grid edge ends the sideways search.
            if (nok) begin
               acol = CW'(ncand); cmd.rd = 1'b1;
               tx_in = CW'(ncand); ty_in = y_ff;
               state_in = S_SGOT;
            end else begin
               state_in = S_NEXT;
            end
         end
         S_SGOT: begin
            // An occupied cell is stepped over.
            if (mem_rdata == fsand_pkg::K_EMPTY) begin
               okind_in = fsand_pkg::K_EMPTY;
               state_in = S_SWAP;
            end else if (step_ff == SW'(SIDE_REACH)) begin
               state_in = S_NEXT;
            end else begin
               step_in = step_ff + SW'(1);
               state_in = S_SIDE;
            end
         end
         S_SWAP: begin
            acol = tx_ff; arow = ty_ff; wdata = kind_ff; cmd.wr = 1'b1;
            state_in = S_SWB;
         end
         S_SWB: begin
            wdata = okind_ff; cmd.wr = 1'b1;
            state_in = S_NEXT;
         end
         S_NEXT: begin
            if (cnt_ff == LAST_COL) begin
               if (y_ff == '0) begin
                  rv_in = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  y_in = y_ff - RW'(1);
                  state_in = S_ROW;
               end
            end else begin
               cnt_in = cnt_ff + (CW+1)'(1);
               x_in = ltr_ff ? x_ff + CW'(1) : x_ff - CW'(1);
               state_in = S_HERE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end
endmodule

@@ rtl/core/fsand_dp.sv @@
// Datapath of the falling sand engine: random generator, address forming and
// the grid store. Depends on fsand_pkg and fsand_mem.
module fsand_dp #(
   parameter int CW = 6,
   parameter int RW = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [15:0]           csr_random_seed,
   input  fsand_pkg::dp_cmd_type cmd,
   input  logic [CW-1:0]         acol,
   input  logic [RW-1:0]         arow,
   input  logic [2:0]            wdata,
   output logic                  rnd_bit,
   output logic [2:0]            mem_rdata
);
   logic [15:0] lfsr_ff, lfsr_in;
   logic [CW+RW-1:0] addr;

   assign addr = {arow, acol};
   assign rnd_bit = lfsr_ff[0];

   always_comb begin
      lfsr_in = lfsr_ff;
      if (csr_write) lfsr_in = (csr_random_seed == 16'd0) ? 16'd1 : csr_random_seed;
      else if (cmd.draw) lfsr_in = fsand_pkg::lfsr_next(lfsr_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) lfsr_ff <= 16'd1;
      else       lfsr_ff <= lfsr_in;
   end

   fsand_mem #(.DEPTH(1 << (CW + RW)), .AW(CW + RW)) u_mem (
      .clock   (clock),
      .wr_en   (cmd.wr),
      .wr_addr (addr),
      .wr_data (wdata),
      .rd_en   (cmd.rd),
      .rd_addr (addr),
      .rd_data (mem_rdata)
   );
endmodule

@@ rtl/core/falling_sand_grid_engine.sv @@
// Falling sand grid engine: holds a grid of material cells and applies cell
// writes, cell reads and simulation ticks. Depends on fsand_pkg, fsand_ctrl, fsand_dp.
//
// After reset the grid store is swept to empty, one cell a cycle (all 4096 cells
// at the default 64 by 64 size), during which no request is taken. One request
// is worked on at a time, and a new one is only taken once the previous
// response has been accepted. A write is answered the cycle after it is
// accepted, a read once S_READ has taken the registered store output. A tick
// visits every cell of every row but the bottom one through the single-ported
// grid store: each row starts with a direction draw, then each cell is read.
// An empty or stone cell is left as it is; a cell that can move also reads the
// cell below and swaps with it if it may sink there, else tries both diagonals,
// and water that finds no room there looks up to SIDE_REACH cells sideways.
// The random seed may only be written while no request is in flight.
module falling_sand_grid_engine #(
   parameter int GRID_COLS  = fsand_pkg::GRID_COLS_DEF,
   parameter int GRID_ROWS  = fsand_pkg::GRID_ROWS_DEF,
   parameter int SIDE_REACH = fsand_pkg::SIDE_REACH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [15:0] csr_random_seed,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [5:0]  req_col,
   input  logic [5:0]  req_row,
   input  logic [2:0]  req_cell_kind,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_op_echo,
   output logic [2:0]  rsp_read_kind
);
   localparam int CW = $clog2(GRID_COLS);
   localparam int RW = $clog2(GRID_ROWS);

   fsand_pkg::dp_cmd_type cmd;
   logic [CW-1:0] acol;
   logic [RW-1:0] arow;
   logic [2:0] wdata, mem_rdata;
   logic rnd_bit;

   fsand_ctrl #(.GRID_COLS(GRID_COLS), .GRID_ROWS(GRID_ROWS),
                .SIDE_REACH(SIDE_REACH), .CW(CW), .RW(RW)) u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req_func, .req_col, .req_row,
      .req_cell_kind, .rsp_valid, .rsp_ready, .rsp_op_echo, .rsp_read_kind,
      .rnd_bit, .mem_rdata, .cmd, .acol, .arow, .wdata
   );

   fsand_dp #(.CW(CW), .RW(RW)) u_dp (
      .clock, .reset, .csr_write, .csr_random_seed, .cmd, .acol, .arow, .wdata,
      .rnd_bit, .mem_rdata
   );
endmodule

@@ rtl/core/fsand_checker.sv @@
// Port checker for the falling sand grid engine, bound to the top level.
// Depends on fsand_pkg.
module fsand_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_op_echo,
   input logic [2:0] rsp_read_kind
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_op_echo))
      else $error("response dropped while stalled");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while response pending");
   a_kind_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_op_echo != fsand_pkg::F_READ |-> rsp_read_kind == fsand_pkg::K_EMPTY)
      else $error("non-read response carries a material");
endmodule

bind falling_sand_grid_engine fsand_checker u_chk (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
   .rsp_op_echo, .rsp_read_kind
);
